// File: hw/rtl/point_collision_query_core_assert.svh
// Assertion macros for point_collision_query_core.
// Included by the top level; the macros expand to nothing when SYNTH is defined.
`ifndef POINT_COLLISION_QUERY_CORE_ASSERT_SVH
`define POINT_COLLISION_QUERY_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define PCQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcq assertion failed");
// Next-cycle implication.
`define PCQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcq assertion failed");
`else
`define PCQ_ASSERT_NOW(label, clk, rst, ante, cons)
`define PCQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/pcq_pkg.sv
// Shared types, codes and constants of the point collision query core.
// No dependencies; the design files refer to it by scoped names, the testbench imports it.
package pcq_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int MAX_FACES    = 256;
  localparam int VERT_AW      = $clog2(MAX_VERTICES);
  localparam int FACE_AW      = $clog2(MAX_FACES);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 31;
  localparam int MARGIN_SCALE = 3;

  // request commands
  localparam logic [1:0] CMD_LOAD_VERTEX = 2'd0;
  localparam logic [1:0] CMD_LOAD_FACE   = 2'd1;
  localparam logic [1:0] CMD_QUERY       = 2'd2;
  localparam logic [1:0] CMD_UNUSED      = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_SHAPE_KIND = 3'd0;
  localparam logic [2:0] REG_CENTER_X   = 3'd1;
  localparam logic [2:0] REG_CENTER_Y   = 3'd2;
  localparam logic [2:0] REG_CENTER_Z   = 3'd3;
  localparam logic [2:0] REG_RADIUS     = 3'd4;
  localparam logic [2:0] REG_THICKNESS  = 3'd5;
  localparam logic [2:0] REG_FACE_COUNT = 3'd6;

  localparam logic SHAPE_SPHERE = 1'b0;
  localparam logic SHAPE_BOX    = 1'b1;

  // cross product operand order: (e1[i1] * e2[i2]) pairs, x=0 y=1 z=2
  localparam logic [1:0] CROSS_I1 [6] = '{2'd1, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1};
  localparam logic [1:0] CROSS_I2 [6] = '{2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0};

  typedef enum logic [1:0] {KIND_VERTEX, KIND_FACE, KIND_QUERY} kind_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [7:0]         slot;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [7:0]         corner_a;
    logic [7:0]         corner_b;
    logic [7:0]         corner_c;
    logic [15:0]        point_id;
  } request_t;

  typedef struct packed {
    logic [15:0]        hit_point;
    logic signed [31:0] distance;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] contact_x;
    logic signed [31:0] contact_y;
    logic signed [31:0] contact_z;
  } result_t;

  typedef struct packed {
    logic               shape_kind;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        radius;
    logic [30:0]        thickness;
    logic [8:0]         face_count;
  } cfg_t;

  typedef struct packed {
    kind_t    kind;
    request_t req;
  } entry_t;

  // magnitude of a difference of two 32-bit signed values
  function automatic logic [31:0] abs33(input logic signed [32:0] v);
    logic signed [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

endpackage

// File: hw/rtl/pcq_queue.sv
// Two-entry request queue between the front and back of the query core.
// Depends on pcq_pkg for the entry type and depth.
module pcq_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pcq_pkg::entry_t push_entry,
  input  logic            pop,
  output pcq_pkg::entry_t head,
  output logic            full,
  output logic            empty
);

  pcq_pkg::entry_t                 slots [pcq_pkg::QUEUE_DEPTH];
  logic [pcq_pkg::QPTR_W-1:0]      wr_ptr;
  logic [pcq_pkg::QPTR_W-1:0]      rd_ptr;
  logic [pcq_pkg::QPTR_W:0]        count;

  assign full  = (count == (pcq_pkg::QPTR_W+1)'(pcq_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/pcq_front.sv
// Front end: configuration registers, request acceptance and classification.
// Depends on pcq_pkg; feeds pcq_queue.
module pcq_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pcq_pkg::request_t item,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              q_full,
  output logic              q_push,
  output pcq_pkg::entry_t   q_entry,
  output pcq_pkg::cfg_t     cfg
);

  logic keep;

  assign busy = q_full;

  always_comb begin
    keep         = 1'b1;
    q_entry.req  = item;
    q_entry.kind = pcq_pkg::KIND_QUERY;
    unique case (item.command)
      pcq_pkg::CMD_LOAD_VERTEX: q_entry.kind = pcq_pkg::KIND_VERTEX;
      pcq_pkg::CMD_LOAD_FACE:   q_entry.kind = pcq_pkg::KIND_FACE;
      pcq_pkg::CMD_QUERY:       q_entry.kind = pcq_pkg::KIND_QUERY;
      default:                  keep = 1'b0;  // drop unused command
    endcase
  end

  assign q_push = start && !q_full && keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shape_kind <= pcq_pkg::SHAPE_SPHERE;
      cfg.center_x   <= '0;
      cfg.center_y   <= '0;
      cfg.center_z   <= '0;
      cfg.radius     <= 31'd65536;
      cfg.thickness  <= '0;
      cfg.face_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcq_pkg::REG_SHAPE_KIND: cfg.shape_kind <= cfg_data[0];
        pcq_pkg::REG_CENTER_X:   cfg.center_x   <= cfg_data;
        pcq_pkg::REG_CENTER_Y:   cfg.center_y   <= cfg_data;
        pcq_pkg::REG_CENTER_Z:   cfg.center_z   <= cfg_data;
        pcq_pkg::REG_RADIUS:     cfg.radius     <= cfg_data[30:0];
        pcq_pkg::REG_THICKNESS:  cfg.thickness  <= cfg_data[30:0];
        pcq_pkg::REG_FACE_COUNT: cfg.face_count <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/pcq_sqrt.sv
// Bit-serial floor square root of a 64-bit value, one result bit per cycle.
// Depends on pcq_pkg for the step count.
module pcq_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        run,
  output logic [31:0] root
);

  logic [63:0] rad;
  logic [33:0] rem;
  logic [5:0]  cnt;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic [35:0] diff;
  logic        take;

  assign rem_sh = {rem, rad[63:62]};
  assign trial  = {2'b00, root, 2'b01};
  assign take   = (rem_sh >= trial);
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      rad  <= value;
      root <= '0;
      rem  <= '0;
      cnt  <= 6'(pcq_pkg::SQRT_STEPS);
      run  <= 1'b1;
    end else if (run) begin
      rad  <= {rad[61:0], 2'b00};
      root <= {root[30:0], take};
      rem  <= take ? diff[33:0] : rem_sh[33:0];
      cnt  <= cnt - 1'b1;
      if (cnt == 6'd1) begin
        run <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/pcq_div.sv
// Restoring divider for unit-normal components; quotient known below 2^31.
// Depends on pcq_pkg for the step count.
module pcq_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [62:0] num,
  input  logic [31:0] den,
  output logic        run,
  output logic [30:0] quot
);

  logic [31:0] rem;
  logic [30:0] low;
  logic [4:0]  cnt;
  logic [32:0] t;
  logic [32:0] t_sub;
  logic        ge;

  assign t     = {rem, low[30]};
  assign ge    = (t >= {1'b0, den});
  assign t_sub = t - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      rem  <= num[62:31];
      low  <= num[30:0];
      quot <= '0;
      cnt  <= 5'(pcq_pkg::DIV_STEPS);
      run  <= 1'b1;
    end else if (run) begin
      rem  <= ge ? t_sub[31:0] : t[31:0];
      low  <= {low[29:0], 1'b0};
      quot <= {quot[29:0], ge};
      cnt  <= cnt - 1'b1;
      if (cnt == 5'd1) begin
        run <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/pcq_back.sv
// Back end: vertex and face stores, shared multiplier and the query sequencer.
// Depends on pcq_pkg, pcq_sqrt and pcq_div.
module pcq_back (
  input  logic              clk,
  input  logic              rst,
  input  pcq_pkg::cfg_t     cfg,
  input  logic              q_empty,
  input  pcq_pkg::entry_t   q_head,
  output logic              q_pop,
  output logic              result_strobe,
  output pcq_pkg::result_t  result
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vertex_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
  } face_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SPH_MUL, S_SPH_CHECK, S_BOX_CHECK, S_FACE_RD, S_VERT_RD, S_EDGE,
    S_CROSS, S_MAG, S_SHIFT, S_SQSUM, S_SQRT_GO, S_SQRT_WAIT, S_DIV_GO,
    S_DIV_WAIT, S_SPH_DONE, S_DOT, S_CMP, S_BOX_DONE
  } state_t;

  state_t state;
  logic [2:0] step;
  logic [2:0] kt;
  logic       is_box;

  // stores
  vertex_t vert_mem [pcq_pkg::MAX_VERTICES];
  face_t   face_mem [pcq_pkg::MAX_FACES];
  vertex_t vert_rd;
  face_t   face_rd;
  logic [pcq_pkg::VERT_AW-1:0] vert_raddr;
  logic vert_we;
  logic face_we;

  // datapath registers
  logic signed [31:0] pt [3];
  logic [15:0]        pid;
  logic [65:0]        sq_acc;
  logic [63:0]        lim;
  logic [31:0]        comp_mag [3];
  logic               comp_neg [3];
  logic [31:0]        len;
  logic [30:0]        nq [3];
  logic signed [31:0] va [3];
  logic signed [31:0] vb [3];
  logic signed [31:0] vc [3];
  logic signed [32:0] e1 [3];
  logic signed [32:0] e2 [3];
  logic signed [32:0] pd [3];
  logic signed [65:0] cross_tmp;
  logic signed [65:0] cr [3];
  logic [64:0]        cmag [3];
  logic [63:0]        acc;
  logic [33:0]        best;
  logic signed [31:0] best_n [3];
  logic [8:0]         f;
  logic [63:0]        prod;

  // combinational
  logic signed [31:0] ctr [3];
  logic signed [32:0] dsph [3];
  logic signed [32:0] dbox [3];
  logic [31:0]        bound;
  logic [8:0]         fcnt;
  logic [8:0]         nfaces;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic signed [65:0] sp;
  logic [63:0]        dot_term;
  logic [64:0]        mag_or;
  logic [63:0]        dot_abs;
  logic [63:0]        dot_rnd;
  logic [33:0]        face_dist;
  logic signed [31:0] cur_n [3];
  logic               box_out;
  logic               sqrt_start;
  logic               sqrt_run;
  logic [31:0]        sqrt_root;
  logic               div_start;
  logic [62:0]        div_num [3];
  logic               div_run [3];
  logic [30:0]        div_quot [3];

  assign ctr[0] = cfg.center_x;
  assign ctr[1] = cfg.center_y;
  assign ctr[2] = cfg.center_z;
  assign bound  = {1'b0, cfg.radius} + {1'b0, cfg.thickness};
  assign fcnt   = (cfg.face_count > 9'(pcq_pkg::MAX_FACES)) ? 9'(pcq_pkg::MAX_FACES)
                                                            : cfg.face_count;
  assign nfaces = (fcnt == '0) ? 9'd1 : fcnt;
  assign kt     = (step == 3'd0) ? 3'd0 : step - 3'd1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dsph[i]  = {ctr[i][31], ctr[i]} - {pt[i][31], pt[i]};
      dbox[i]  = {pt[i][31], pt[i]} - {ctr[i][31], ctr[i]};
      div_num[i] = {comp_mag[i], 30'd0} + {32'd0, len[31:1]};
      cur_n[i] = comp_neg[i] ? -$signed({1'b0, nq[i]}) : $signed({1'b0, nq[i]});
    end
    box_out = (pcq_pkg::abs33(dbox[0]) > bound) || (pcq_pkg::abs33(dbox[1]) > bound)
           || (pcq_pkg::abs33(dbox[2]) > bound);
  end

  // store ports
  assign q_pop   = (state == S_IDLE) && !q_empty;
  assign vert_we = q_pop && (q_head.kind == pcq_pkg::KIND_VERTEX);
  assign face_we = q_pop && (q_head.kind == pcq_pkg::KIND_FACE);

  always_comb begin
    case (step)
      3'd0:    vert_raddr = face_rd.a;
      3'd1:    vert_raddr = face_rd.b;
      default: vert_raddr = face_rd.c;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vert_we) begin
      vert_mem[q_head.req.slot] <= {q_head.req.coord_x, q_head.req.coord_y,
                                    q_head.req.coord_z};
    end
    vert_rd <= vert_mem[vert_raddr];
  end

  always_ff @(posedge clk) begin
    if (face_we) begin
      face_mem[q_head.req.slot] <= {q_head.req.corner_a, q_head.req.corner_b,
                                    q_head.req.corner_c};
    end
    face_rd <= face_mem[f[pcq_pkg::FACE_AW-1:0]];
  end

  // shared multiplier, operands chosen by state and step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SPH_MUL: begin
        if (step < 3'd3) begin
          mul_a = pcq_pkg::abs33(dsph[step[1:0]]);
          mul_b = mul_a;
        end else begin
          mul_a = bound;
          mul_b = bound;
        end
      end
      S_CROSS: begin
        if (step < 3'd6) begin
          mul_a = pcq_pkg::abs33(e1[pcq_pkg::CROSS_I1[step]]);
          mul_b = pcq_pkg::abs33(e2[pcq_pkg::CROSS_I2[step]]);
        end
      end
      S_SQSUM: begin
        if (step < 3'd3) begin
          mul_a = comp_mag[step[1:0]];
          mul_b = comp_mag[step[1:0]];
        end
      end
      S_DOT: begin
        if (step < 3'd3) begin
          mul_a = {1'b0, nq[step[1:0]]};
          mul_b = pcq_pkg::abs33(pd[step[1:0]]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // signed forms of the product taken this cycle
  always_comb begin
    sp = $signed({2'b00, prod});
    if (kt < 3'd6) begin
      if (e1[pcq_pkg::CROSS_I1[kt]][32] ^ e2[pcq_pkg::CROSS_I2[kt]][32]) begin
        sp = -$signed({2'b00, prod});
      end
    end
    dot_term = prod;
    if (kt < 3'd3) begin
      if (comp_neg[kt[1:0]] ^ pd[kt[1:0]][32]) begin
        dot_term = -prod;
      end
    end
    mag_or    = cmag[0] | cmag[1] | cmag[2];
    dot_abs   = acc[63] ? -acc : acc;
    dot_rnd   = dot_abs + 64'd536870912;
    face_dist = dot_rnd[63:30];
  end

  assign sqrt_start = (state == S_SQRT_GO);
  assign div_start  = (state == S_DIV_GO);

  pcq_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (sq_acc[63:0]),
    .run   (sqrt_run),
    .root  (sqrt_root)
  );

  pcq_div u_div_x (
    .clk (clk), .rst (rst), .start (div_start), .num (div_num[0]), .den (len),
    .run (div_run[0]), .quot (div_quot[0])
  );

  pcq_div u_div_y (
    .clk (clk), .rst (rst), .start (div_start), .num (div_num[1]), .den (len),
    .run (div_run[1]), .quot (div_quot[1])
  );

  pcq_div u_div_z (
    .clk (clk), .rst (rst), .start (div_start), .num (div_num[2]), .den (len),
    .run (div_run[2]), .quot (div_quot[2])
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty && q_head.kind == pcq_pkg::KIND_QUERY) begin
            pt[0]  <= q_head.req.coord_x;
            pt[1]  <= q_head.req.coord_y;
            pt[2]  <= q_head.req.coord_z;
            pid    <= q_head.req.point_id;
            is_box <= cfg.shape_kind;
            step   <= '0;
            sq_acc <= '0;
            state  <= (cfg.shape_kind == pcq_pkg::SHAPE_BOX) ? S_BOX_CHECK : S_SPH_MUL;
          end
        end
        S_SPH_MUL: begin
          if (step != 3'd0) begin
            if (kt == 3'd3) begin
              lim <= prod;
            end else begin
              sq_acc <= sq_acc + {2'b00, prod};
            end
          end
          if (step == 3'd4) begin
            state <= S_SPH_CHECK;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_SPH_CHECK: begin
          if (sq_acc > {2'b00, lim}) begin
            state <= S_IDLE;
          end else begin
            for (int i = 0; i < 3; i++) begin
              comp_mag[i] <= pcq_pkg::abs33(dsph[i]);
              comp_neg[i] <= dsph[i][32];
            end
            state <= S_SQRT_GO;
          end
        end
        S_BOX_CHECK: begin
          if (box_out) begin
            state <= S_IDLE;
          end else begin
            best  <= 34'({3'b000, cfg.thickness} * 34'(pcq_pkg::MARGIN_SCALE));
            f     <= '0;
            state <= S_FACE_RD;
          end
        end
        S_FACE_RD: begin
          step  <= '0;
          state <= S_VERT_RD;
        end
        S_VERT_RD: begin
          // vertex reads return in the cycle after the address
          case (step)
            3'd1: {va[0], va[1], va[2]} <= vert_rd;
            3'd2: {vb[0], vb[1], vb[2]} <= vert_rd;
            3'd3: {vc[0], vc[1], vc[2]} <= vert_rd;
            default: ;
          endcase
          if (step == 3'd3) begin
            state <= S_EDGE;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_EDGE: begin
          for (int i = 0; i < 3; i++) begin
            e1[i] <= {vb[i][31], vb[i]} - {va[i][31], va[i]};
            e2[i] <= {vc[i][31], vc[i]} - {va[i][31], va[i]};
            pd[i] <= {pt[i][31], pt[i]} - {va[i][31], va[i]};
          end
          step  <= '0;
          state <= S_CROSS;
        end
        S_CROSS: begin
          if (step != 3'd0) begin
            if (!kt[0]) begin
              cross_tmp <= sp;
            end else begin
              cr[kt[2:1]] <= cross_tmp - sp;
            end
          end
          if (step == 3'd6) begin
            state <= S_MAG;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_MAG: begin
          for (int i = 0; i < 3; i++) begin
            cmag[i]     <= cr[i][65] ? 65'(-cr[i]) : cr[i][64:0];
            comp_neg[i] <= cr[i][65];
          end
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          // bring the largest magnitude to exactly 31 bits
          step <= '0;
          if (mag_or == '0) begin
            for (int i = 0; i < 3; i++) begin
              nq[i]       <= '0;
              comp_neg[i] <= 1'b0;
            end
            acc   <= '0;
            state <= S_DOT;
          end else if (mag_or[64:38] != '0) begin
            for (int i = 0; i < 3; i++) cmag[i] <= cmag[i] >> 8;
          end else if (mag_or[64:31] != '0) begin
            for (int i = 0; i < 3; i++) cmag[i] <= cmag[i] >> 1;
          end else if (mag_or[30:23] == '0) begin
            for (int i = 0; i < 3; i++) cmag[i] <= cmag[i] << 8;
          end else if (!mag_or[30]) begin
            for (int i = 0; i < 3; i++) cmag[i] <= cmag[i] << 1;
          end else begin
            for (int i = 0; i < 3; i++) comp_mag[i] <= {1'b0, cmag[i][30:0]};
            sq_acc <= '0;
            state  <= S_SQSUM;
          end
        end
        S_SQSUM: begin
          if (step != 3'd0) begin
            sq_acc <= sq_acc + {2'b00, prod};
          end
          if (step == 3'd3) begin
            state <= S_SQRT_GO;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_SQRT_GO: begin
          state <= S_SQRT_WAIT;
        end
        S_SQRT_WAIT: begin
          if (!sqrt_run) begin
            len <= sqrt_root;
            if (sqrt_root == '0) begin
              // point at the center: zero normal
              for (int i = 0; i < 3; i++) nq[i] <= '0;
              step  <= '0;
              acc   <= '0;
              state <= is_box ? S_DOT : S_SPH_DONE;
            end else begin
              state <= S_DIV_GO;
            end
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (!div_run[0] && !div_run[1] && !div_run[2]) begin
            for (int i = 0; i < 3; i++) nq[i] <= div_quot[i];
            step  <= '0;
            acc   <= '0;
            state <= is_box ? S_DOT : S_SPH_DONE;
          end
        end
        S_SPH_DONE: begin
          result.hit_point <= pid;
          result.distance  <= len - {1'b0, cfg.radius};
          result.normal_x  <= cur_n[0];
          result.normal_y  <= cur_n[1];
          result.normal_z  <= cur_n[2];
          result.contact_x <= pt[0];
          result.contact_y <= pt[1];
          result.contact_z <= pt[2];
          result_strobe    <= 1'b1;
          state            <= S_IDLE;
        end
        S_DOT: begin
          if (step != 3'd0) begin
            acc <= acc + dot_term;
          end
          if (step == 3'd3) begin
            state <= S_CMP;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_CMP: begin
          // face 0 supplies the normal until a closer face wins
          if (f == '0) begin
            for (int i = 0; i < 3; i++) best_n[i] <= cur_n[i];
          end
          if (f < fcnt && face_dist < best) begin
            best <= face_dist;
            for (int i = 0; i < 3; i++) best_n[i] <= cur_n[i];
          end
          f <= f + 1'b1;
          state <= (f + 1'b1 == nfaces) ? S_BOX_DONE : S_FACE_RD;
        end
        S_BOX_DONE: begin
          result.hit_point <= pid;
          result.distance  <= (best > 34'h07FFFFFFF) ? 32'h7FFFFFFF : best[31:0];
          result.normal_x  <= best_n[0];
          result.normal_y  <= best_n[1];
          result.normal_z  <= best_n[2];
          result.contact_x <= pt[0];
          result.contact_y <= pt[1];
          result.contact_z <= pt[2];
          result_strobe    <= 1'b1;
          state            <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/point_collision_query_core.sv
// Top level of the point collision query core: front, queue and back.
// Depends on pcq_pkg, pcq_front, pcq_queue, pcq_back and the assertion header.
//
//   channel   ports                              handshake
//   request   start, busy, item                  taken when start && !busy
//   result    result_strobe, result              valid for one cycle, no stall
//   config    cfg_we, cfg_index, cfg_data        written when cfg_we is high
//
// Loads are written into the stores as the back end pops them. A box query walks
// every configured face (at least one) and runs the bit-serial square root and the
// three bit-serial dividers for each face that is not degenerate.
// Reset sets control and configuration state; the stores hold garbage until loaded.
// busy rises while the two-entry queue is full; results are never held back.
`include "point_collision_query_core_assert.svh"

module point_collision_query_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pcq_pkg::request_t item,
  output logic              result_strobe,
  output pcq_pkg::result_t  result,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  pcq_pkg::cfg_t   cfg;
  pcq_pkg::entry_t q_entry;
  pcq_pkg::entry_t q_head;
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;

  pcq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry),
    .cfg       (cfg)
  );

  pcq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  pcq_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .result_strobe (result_strobe),
    .result        (result)
  );

  `PCQ_ASSERT_NEXT(a_strobe_single, clk, rst, result_strobe, !result_strobe)
  `PCQ_ASSERT_NOW(a_pop_nonempty, clk, rst, q_pop, !q_empty)
  `PCQ_ASSERT_NOW(a_unused_dropped, clk, rst, start && item.command == pcq_pkg::CMD_UNUSED, !q_push)

endmodule

// File: tb/testbench.sv
// Self-checking testbench for point_collision_query_core: loads, sphere and box queries.
// Depends on pcq_pkg; a scoreboard class predicts each hit and compares it with the block.
module testbench;
  import pcq_pkg::*;

  localparam int LIMIT = 4000000;

  class collision_scoreboard;
    result_t            hits[$];
    int                 mismatches = 0;
    int                 predicted = 0;
    int                 seen = 0;
    logic signed [31:0] vx[256], vy[256], vz[256];
    logic [7:0]         fa[256], fb[256], fc[256];
    cfg_t               cfg;
    longint             nrm[3], base[3];

    function new();
      cfg = '0;
      cfg.radius = 31'd65536;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_SHAPE_KIND: cfg.shape_kind = v[0];
        REG_CENTER_X:   cfg.center_x = v;
        REG_CENTER_Y:   cfg.center_y = v;
        REG_CENTER_Z:   cfg.center_z = v;
        REG_RADIUS:     cfg.radius = v[30:0];
        REG_THICKNESS:  cfg.thickness = v[30:0];
        REG_FACE_COUNT: cfg.face_count = v[8:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] floor_root(logic [67:0] v);
      logic [71:0] rem, trial;
      logic [63:0] r;
      r = 0;
      rem = 0;
      for (int k = 33; k >= 0; k--) begin
        rem = (rem << 2) | 72'((v >> (2 * k)) & 68'd3);
        trial = {6'd0, r, 2'b01};
        if (rem >= trial) begin
          rem = rem - trial;
          r = {r[62:0], 1'b1};
        end else begin
          r = r << 1;
        end
      end
      return r;
    endfunction

    function longint unit_of(longint c, logic [63:0] len);
      logic [63:0] m, q;
      if (len == 0) return 0;
      m = c < 0 ? -c : c;
      q = ((m << 30) + (len >> 1)) / len;
      return c < 0 ? -longint'(q) : longint'(q);
    endfunction

    function logic signed [127:0] wide_mul(longint x, longint y);
      logic signed [127:0] a, b;
      a = x;
      b = y;
      return a * b;
    endfunction

    // unit normal of face f into nrm, its first corner into base
    function void face_normal(int f);
      longint va[3], vb[3], vc[3], e1[3], e2[3];
      logic signed [127:0] cr[3];
      logic [127:0] mg[3];
      logic [63:0] s[3], sum, len;
      int blen;
      va = '{vx[fa[f]], vy[fa[f]], vz[fa[f]]};
      vb = '{vx[fb[f]], vy[fb[f]], vz[fb[f]]};
      vc = '{vx[fc[f]], vy[fc[f]], vz[fc[f]]};
      for (int i = 0; i < 3; i++) begin
        e1[i] = vb[i] - va[i];
        e2[i] = vc[i] - va[i];
        base[i] = va[i];
      end
      cr[0] = wide_mul(e1[1], e2[2]) - wide_mul(e1[2], e2[1]);
      cr[1] = wide_mul(e1[2], e2[0]) - wide_mul(e1[0], e2[2]);
      cr[2] = wide_mul(e1[0], e2[1]) - wide_mul(e1[1], e2[0]);
      blen = 0;
      for (int i = 0; i < 3; i++) begin
        mg[i] = cr[i] < 0 ? -cr[i] : cr[i];
        for (int j = 127; j >= 0; j--)
          if (mg[i][j] && j + 1 > blen) blen = j + 1;
      end
      if (blen == 0) begin
        nrm = '{0, 0, 0};
        return;
      end
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        if (blen > 31) s[i] = 64'(mg[i] >> (blen - 31));
        else s[i] = 64'(mg[i] << (31 - blen));
        sum = sum + s[i] * s[i];
      end
      len = floor_root({4'd0, sum});
      for (int i = 0; i < 3; i++)
        nrm[i] = unit_of(cr[i] < 0 ? -longint'(s[i]) : longint'(s[i]), len);
    endfunction

    function void note(request_t r);
      longint p[3], c[3], d[3], bound, best, face_dist;
      logic [67:0] sq, lim, m;
      logic [63:0] len, acc, mag;
      int cnt, best_f;
      result_t h;
      case (r.command)
        CMD_LOAD_VERTEX: begin
          vx[r.slot] = r.coord_x;
          vy[r.slot] = r.coord_y;
          vz[r.slot] = r.coord_z;
        end
        CMD_LOAD_FACE: begin
          fa[r.slot] = r.corner_a;
          fb[r.slot] = r.corner_b;
          fc[r.slot] = r.corner_c;
        end
        CMD_QUERY: begin
          p = '{r.coord_x, r.coord_y, r.coord_z};
          c = '{cfg.center_x, cfg.center_y, cfg.center_z};
          bound = longint'(cfg.radius) + longint'(cfg.thickness);
          h.hit_point = r.point_id;
          h.contact_x = r.coord_x;
          h.contact_y = r.coord_y;
          h.contact_z = r.coord_z;
          if (cfg.shape_kind == SHAPE_SPHERE) begin
            sq = 0;
            for (int i = 0; i < 3; i++) begin
              d[i] = c[i] - p[i];
              m = d[i] < 0 ? -d[i] : d[i];
              sq = sq + m * m;
            end
            lim = 68'(bound) * 68'(bound);
            if (sq > lim) return;
            len = floor_root(sq);
            h.distance = 32'(longint'(len) - longint'(cfg.radius));
            h.normal_x = 32'(unit_of(d[0], len));
            h.normal_y = 32'(unit_of(d[1], len));
            h.normal_z = 32'(unit_of(d[2], len));
          end else begin
            for (int i = 0; i < 3; i++) begin
              d[i] = p[i] - c[i];
              if ((d[i] < 0 ? -d[i] : d[i]) > bound) return;
            end
            best = 3 * longint'(cfg.thickness);
            best_f = 0;
            cnt = cfg.face_count > MAX_FACES ? MAX_FACES : cfg.face_count;
            for (int f = 0; f < cnt; f++) begin
              face_normal(f);
              acc = 0;
              for (int i = 0; i < 3; i++) acc = acc + 64'(nrm[i] * (p[i] - base[i]));
              mag = acc[63] ? -acc : acc;
              face_dist = longint'((mag + 64'(1 << 29)) >> 30);
              if (face_dist < best) begin
                best = face_dist;
                best_f = f;
              end
            end
            face_normal(best_f);
            if (best > 64'h7FFFFFFF) best = 64'h7FFFFFFF;
            h.distance = 32'(best);
            h.normal_x = 32'(nrm[0]);
            h.normal_y = 32'(nrm[1]);
            h.normal_z = 32'(nrm[2]);
          end
          hits = {hits, h};
          predicted++;
        end
        default: ;
      endcase
    endfunction

    function void check(result_t got);
      result_t want;
      seen++;
      if (hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected hit for point %0d", got.hit_point);
        return;
      end
      want = hits.pop_front();
      if (got.hit_point !== want.hit_point || got.distance !== want.distance ||
          got.normal_x !== want.normal_x || got.normal_y !== want.normal_y ||
          got.normal_z !== want.normal_z || got.contact_x !== want.contact_x ||
          got.contact_y !== want.contact_y || got.contact_z !== want.contact_z) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp id %h dist %h n %h %h %h p %h %h %h", want.hit_point,
                   want.distance, want.normal_x, want.normal_y, want.normal_z,
                   want.contact_x, want.contact_y, want.contact_z);
          $display("         got id %h dist %h n %h %h %h p %h %h %h", got.hit_point,
                   got.distance, got.normal_x, got.normal_y, got.normal_z,
                   got.contact_x, got.contact_y, got.contact_z);
        end
      end
    endfunction

    function int pending();
      return hits.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  request_t    item = '0;
  logic        result_strobe;
  result_t     result;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  collision_scoreboard sb = new();
  cfg_t cur;
  int   cycles = 0;
  int   accepted = 0;
  int   queries = 0;
  bit   calm = 1'b0;

  point_collision_query_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_strobe(result_strobe), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("point_collision_query_core regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_strobe) sb.check(result);
  end

  // hold the request until the block takes it
  task automatic send(request_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(r);
    accepted++;
    if (r.command == CMD_QUERY) queries++;
    if (accepted % 40 == 0) calm = ($urandom_range(0, 3) == 0);
  endtask

  // drain all hits, then let loads and misses still in flight finish
  task automatic settle();
    int faces;
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    faces = cur.face_count > MAX_FACES ? MAX_FACES : cur.face_count;
    repeat (3 * 110 * (faces + 1) + 200) @(posedge clk);
  endtask

  task automatic write_config(cfg_t c);
    logic [31:0] vals[7];
    vals = '{{31'd0, c.shape_kind}, c.center_x, c.center_y, c.center_z,
             {1'b0, c.radius}, {1'b0, c.thickness}, {23'd0, c.face_count}};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(3'(i), vals[i]);
    end
    cfg_we <= 1'b0;
    cur = c;
  endtask

  function automatic logic [31:0] near(logic signed [31:0] ctr, longint span);
    longint off;
    off = longint'({$urandom, $urandom} % (2 * span + 1)) - span;
    if (off < 0) off = -((-off) % (2 * span + 1));
    return 32'(longint'(ctr) + off);
  endfunction

  function automatic request_t rand_fill();
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(request_t)-1:0];
  endfunction

  function automatic request_t rand_req();
    request_t r;
    longint span;
    int pick;
    r = rand_fill();
    span = longint'(cur.radius) + longint'(cur.thickness);
    span = span + span / 8 + 1;
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      r.command = CMD_QUERY;
      r.coord_x = near(cur.center_x, span);
      r.coord_y = near(cur.center_y, span);
      r.coord_z = near(cur.center_z, span);
    end else if (pick < 74) begin
      r.command = CMD_LOAD_VERTEX;
      r.coord_x = near(cur.center_x, cur.radius);
      r.coord_y = near(cur.center_y, cur.radius);
      r.coord_z = near(cur.center_z, cur.radius);
    end else if (pick < 84) begin
      r.command = CMD_LOAD_FACE;
    end else if (pick < 96) begin
      r.command = CMD_QUERY;
    end else begin
      r.command = CMD_UNUSED;
    end
    return r;
  endfunction

  function automatic request_t query_at(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    request_t r;
    r = '0;
    r.command = CMD_QUERY;
    r.point_id = 16'($urandom);
    r.coord_x = x;
    r.coord_y = y;
    r.coord_z = z;
    return r;
  endfunction

  initial begin
    request_t r;
    cfg_t c;
    int n;
    cur = sb.cfg;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill both stores so no query reads an unwritten entry
    for (int i = 0; i < 256; i++) begin
      r = '0;
      r.command = CMD_LOAD_VERTEX;
      r.slot = 8'(i);
      r.coord_x = near(0, 1 << 20);
      r.coord_y = near(0, 1 << 20);
      r.coord_z = near(0, 1 << 20);
      send(r);
    end
    for (int i = 0; i < 256; i++) begin
      r = rand_fill();
      r.command = CMD_LOAD_FACE;
      r.slot = 8'(i);
      // degenerate face: all corners on one vertex
      if (i == 2) begin
        r.corner_b = r.corner_a;
        r.corner_c = r.corner_a;
      end
      send(r);
    end

    // directed: sphere defaults, center hit, extremes, unused command
    send(query_at(0, 0, 0));
    send(query_at(32'h8000, 0, 0));
    send(query_at(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
    r = query_at(0, 0, 0);
    r.command = CMD_UNUSED;
    send(r);
    settle();
    c = '0;
    c.center_x = 32'h7FFFFFFF;
    c.center_y = 32'h80000000;
    c.center_z = 32'h7FFFFFFF;
    c.radius = 31'h7FFFFFFF;
    c.thickness = 31'h7FFFFFFF;
    write_config(c);
    send(query_at(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
    send(query_at(32'h80000000, 32'h7FFFFFFF, 32'h80000000));
    send(query_at(0, 0, 0));
    settle();
    c = '0;
    write_config(c);
    send(query_at(0, 0, 0));
    send(query_at(1, 0, 0));
    settle();
    for (int k = 0; k < 4; k++) begin
      c = '0;
      c.shape_kind = SHAPE_BOX;
      c.radius = 31'h7FFFFFFF;
      c.thickness = k == 0 ? 31'h7FFFFFFF : 31'(1 << 24);
      c.face_count = k == 0 ? 9'd0 : k == 1 ? 9'd3 : k == 2 ? 9'd256 : 9'd511;
      write_config(c);
      send(query_at(near(0, 1 << 20), near(0, 1 << 20), near(0, 1 << 20)));
      send(query_at(32'h80000000, 32'h7FFFFFFF, 0));
      settle();
    end

    // random phases over varied obstacles
    for (int ph = 0; ph < 14; ph++) begin
      c.shape_kind = ph[0];
      c.center_x = near(0, 1 << 24);
      c.center_y = near(0, 1 << 24);
      c.center_z = near(0, 1 << 24);
      c.radius = 31'(1) << $urandom_range(8, 26);
      c.radius = c.radius + 31'($urandom_range(0, 255));
      c.thickness = 31'($urandom) >> $urandom_range(4, 30);
      c.face_count = 9'($urandom_range(0, 5));
      n = 70;
      if (ph == 4) begin
        c.radius = 31'd0;
        c.thickness = 31'd0;
      end
      if (ph == 6 || ph == 9) begin
        c.face_count = ph == 6 ? 9'd256 : 9'd511;
        c.thickness = 31'(1 << 22);
        n = 6;
      end
      if (ph == 11) begin
        c.center_x = 32'h80000000;
        c.center_y = 32'h7FFFFFFF;
        c.radius = 31'h7FFFFFFF;
      end
      write_config(c);
      for (int i = 0; i < n; i++) send(rand_req());
      settle();
    end

    $display("covered %0d requests, %0d queries, %0d hits predicted, %0d hits seen",
             accepted, queries, sb.predicted, sb.seen);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("point_collision_query_core regression: pass");
    end else begin
      $display("point_collision_query_core regression: fail");
    end
    $finish;
  end
endmodule
